### rtl/core/rsort_pkg.sv
// ----------------------------------------------------------------------------
// rsort_pkg: shared types and constants of the radix sorter
// Payload structs, sequencer states and bucket unit control codes.
// ----------------------------------------------------------------------------
package rsort_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DIGIT_BITS_DEF = 8;
  localparam int KEY_WIDTH_DEF  = 32;
  localparam int IN_KEY_W       = 32;
  localparam int OUT_KEY_W      = 32;

  typedef struct packed {
    logic [IN_KEY_W-1:0] key_in;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic [OUT_KEY_W-1:0] key_out;
    logic                 end_of_batch;
    logic                 dropped;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_HIST_PRIME,
    ST_HIST_RD,
    ST_HIST_WR,
    ST_PREFIX,
    ST_SCAT_PRIME,
    ST_SCAT_RD,
    ST_SCAT_WR,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

  // what the bucket memory is written with
  typedef enum logic [1:0] {
    BW_ZERO,
    BW_RUN,
    BW_SUM
  } bkt_wsel_t;

  // operands of the shared adder
  typedef enum logic {
    ADD_INC,
    ADD_RUN
  } bkt_add_t;

  typedef struct packed {
    logic      wr_en;
    bkt_wsel_t wr_sel;
    bkt_add_t  add_sel;
    logic      run_clr;
    logic      run_upd;
  } bkt_ctl_t;

endpackage

### rtl/core/rsort_key_ram.sv
// ----------------------------------------------------------------------------
// rsort_key_ram: key store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsort_key_ram #(
  parameter int DEPTH = rsort_pkg::CAPACITY_DEF,
  parameter int WIDTH = rsort_pkg::KEY_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/rsort_bkt_unit.sv
// ----------------------------------------------------------------------------
// rsort_bkt_unit: bucket table with the shared adder
// Counts digits, forms running offsets and bumps scatter positions.
// ----------------------------------------------------------------------------
module rsort_bkt_unit #(
  parameter int CAPACITY   = rsort_pkg::CAPACITY_DEF,
  parameter int DIGIT_BITS = rsort_pkg::DIGIT_BITS_DEF
) (
  input  logic                           clk,
  input  rsort_pkg::bkt_ctl_t            ctl,
  input  logic [DIGIT_BITS-1:0]          rd_addr,
  input  logic [DIGIT_BITS-1:0]          wr_addr,
  output logic [$clog2(CAPACITY+1)-1:0]  rdata
);

  localparam int BUCKETS = 1 << DIGIT_BITS;
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] mem [BUCKETS];
  logic [CNT_W-1:0] rdata_r;
  logic [CNT_W-1:0] run_r;
  logic [CNT_W-1:0] add_a;
  logic [CNT_W-1:0] add_b;
  logic [CNT_W-1:0] sum;
  logic [CNT_W-1:0] wdata;

  // shared adder: count bump or running offset
  always_comb begin
    case (ctl.add_sel)
      rsort_pkg::ADD_RUN: begin
        add_a = run_r;
        add_b = rdata_r;
      end
      default: begin
        add_a = rdata_r;
        add_b = CNT_W'(1);
      end
    endcase
    sum = add_a + add_b;
  end

  always_comb begin
    case (ctl.wr_sel)
      rsort_pkg::BW_ZERO: wdata = '0;
      rsort_pkg::BW_RUN:  wdata = run_r;
      default:            wdata = sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    rdata_r <= mem[rd_addr];
    if (ctl.run_clr) begin
      run_r <= '0;
    end else if (ctl.run_upd) begin
      run_r <= sum;
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/rsort_seq.sv
// ----------------------------------------------------------------------------
// rsort_seq: sort sequencer
// Loads the batch, steps clear/histogram/prefix/scatter per digit, then
// streams the sorted keys through the output register.
// ----------------------------------------------------------------------------
module rsort_seq #(
  parameter int CAPACITY   = rsort_pkg::CAPACITY_DEF,
  parameter int DIGIT_BITS = rsort_pkg::DIGIT_BITS_DEF,
  parameter int KEY_WIDTH  = rsort_pkg::KEY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rsort_pkg::in_item_t           in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rsort_pkg::out_item_t          out_data,
  output logic                          key_we_a,
  output logic                          key_we_b,
  output logic [$clog2(CAPACITY)-1:0]   key_waddr,
  output logic [KEY_WIDTH-1:0]          key_wdata,
  output logic [$clog2(CAPACITY)-1:0]   key_raddr,
  input  logic [KEY_WIDTH-1:0]          key_rdata_a,
  input  logic [KEY_WIDTH-1:0]          key_rdata_b,
  output rsort_pkg::bkt_ctl_t           bkt_ctl,
  output logic [DIGIT_BITS-1:0]         bkt_raddr,
  output logic [DIGIT_BITS-1:0]         bkt_waddr,
  input  logic [$clog2(CAPACITY+1)-1:0] bkt_rdata
);

  localparam int BUCKETS = 1 << DIGIT_BITS;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int BIDX_W  = DIGIT_BITS + 1;
  localparam int PASSES  = (KEY_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PASS_W  = $clog2(PASSES + 1);
  localparam int SH_W    = $clog2(PASSES * DIGIT_BITS + 1);

  rsort_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]      fill_r;
  logic                  ovf_r;
  logic [PASS_W-1:0]     pass_r;
  logic [SH_W-1:0]       shamt_r;
  logic [CNT_W-1:0]      idx_r;
  logic [BIDX_W-1:0]     bidx_r;
  logic [DIGIT_BITS-1:0] dig_r;
  logic [KEY_WIDTH-1:0]  hold_r;
  logic                  out_valid_r;
  rsort_pkg::out_item_t  out_data_r;

  logic                  in_fire;
  logic                  room;
  logic [CNT_W-1:0]      idx_inc;
  logic                  key_last;
  logic                  pass_last;
  logic                  bidx_last;
  logic                  bidx_done;
  logic [BIDX_W-1:0]     bidx_dec;
  logic [KEY_WIDTH-1:0]  src_q;
  logic [KEY_WIDTH-1:0]  dst_q;
  logic [DIGIT_BITS-1:0] digit;
  logic                  pos_ok;

  assign in_fire   = in_valid && in_ready;
  assign room      = fill_r < CNT_W'(CAPACITY);
  assign idx_inc   = idx_r + 1'b1;
  assign key_last  = idx_inc == fill_r;
  assign pass_last = pass_r == PASS_W'(PASSES - 1);
  assign bidx_last = bidx_r == BIDX_W'(BUCKETS - 1);
  assign bidx_done = bidx_r == BIDX_W'(BUCKETS);
  assign bidx_dec  = bidx_r - 1'b1;
  // even passes read store a and scatter into store b
  assign src_q     = pass_r[0] ? key_rdata_b : key_rdata_a;
  assign dst_q     = pass_r[0] ? key_rdata_a : key_rdata_b;
  assign digit     = DIGIT_BITS'(src_q >> shamt_r);
  assign pos_ok    = bkt_rdata < CNT_W'(CAPACITY);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsort_pkg::ST_LOAD: begin
        if (in_fire && in_data.last) state_nxt = rsort_pkg::ST_CLEAR;
      end
      rsort_pkg::ST_CLEAR: begin
        if (bidx_last) state_nxt = rsort_pkg::ST_HIST_PRIME;
      end
      rsort_pkg::ST_HIST_PRIME: state_nxt = rsort_pkg::ST_HIST_RD;
      rsort_pkg::ST_HIST_RD:    state_nxt = rsort_pkg::ST_HIST_WR;
      rsort_pkg::ST_HIST_WR: begin
        state_nxt = key_last ? rsort_pkg::ST_PREFIX : rsort_pkg::ST_HIST_RD;
      end
      rsort_pkg::ST_PREFIX: begin
        if (bidx_done) state_nxt = rsort_pkg::ST_SCAT_PRIME;
      end
      rsort_pkg::ST_SCAT_PRIME: state_nxt = rsort_pkg::ST_SCAT_RD;
      rsort_pkg::ST_SCAT_RD:    state_nxt = rsort_pkg::ST_SCAT_WR;
      rsort_pkg::ST_SCAT_WR: begin
        if (!key_last) begin
          state_nxt = rsort_pkg::ST_SCAT_RD;
        end else if (pass_last) begin
          state_nxt = rsort_pkg::ST_OUT_RD;
        end else begin
          state_nxt = rsort_pkg::ST_CLEAR;
        end
      end
      rsort_pkg::ST_OUT_RD: state_nxt = rsort_pkg::ST_OUT_LD;
      rsort_pkg::ST_OUT_LD: state_nxt = rsort_pkg::ST_OUT_WAIT;
      rsort_pkg::ST_OUT_WAIT: begin
        if (out_ready) begin
          state_nxt = key_last ? rsort_pkg::ST_LOAD : rsort_pkg::ST_OUT_RD;
        end
      end
      default: state_nxt = rsort_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    key_we_a        = 1'b0;
    key_we_b        = 1'b0;
    key_waddr       = fill_r[IDX_W-1:0];
    key_wdata       = KEY_WIDTH'(in_data.key_in);
    key_raddr       = idx_r[IDX_W-1:0];
    bkt_ctl.wr_en   = 1'b0;
    bkt_ctl.wr_sel  = rsort_pkg::BW_SUM;
    bkt_ctl.add_sel = rsort_pkg::ADD_INC;
    bkt_ctl.run_clr = 1'b0;
    bkt_ctl.run_upd = 1'b0;
    bkt_raddr       = bidx_r[DIGIT_BITS-1:0];
    bkt_waddr       = dig_r;
    case (state_r)
      rsort_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        key_we_a = in_fire && room;
      end
      rsort_pkg::ST_CLEAR: begin
        bkt_ctl.wr_en   = 1'b1;
        bkt_ctl.wr_sel  = rsort_pkg::BW_ZERO;
        bkt_ctl.run_clr = 1'b1;
        bkt_waddr       = bidx_r[DIGIT_BITS-1:0];
      end
      rsort_pkg::ST_HIST_RD, rsort_pkg::ST_SCAT_RD: begin
        key_raddr = idx_inc[IDX_W-1:0];
        bkt_raddr = digit;
      end
      rsort_pkg::ST_HIST_WR: begin
        key_raddr     = idx_inc[IDX_W-1:0];
        bkt_ctl.wr_en = 1'b1;
      end
      rsort_pkg::ST_PREFIX: begin
        // read bucket b while bucket b-1 takes the running offset
        bkt_ctl.wr_en   = bidx_r != '0;
        bkt_ctl.wr_sel  = rsort_pkg::BW_RUN;
        bkt_ctl.add_sel = rsort_pkg::ADD_RUN;
        bkt_ctl.run_upd = bidx_r != '0;
        bkt_waddr       = bidx_dec[DIGIT_BITS-1:0];
      end
      rsort_pkg::ST_SCAT_WR: begin
        key_raddr     = idx_inc[IDX_W-1:0];
        key_we_a      = pos_ok && pass_r[0];
        key_we_b      = pos_ok && !pass_r[0];
        key_waddr     = bkt_rdata[IDX_W-1:0];
        key_wdata     = hold_r;
        bkt_ctl.wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsort_pkg::ST_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      pass_r      <= '0;
      shamt_r     <= '0;
      idx_r       <= '0;
      bidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        rsort_pkg::ST_LOAD: begin
          if (in_fire) begin
            if (room) begin
              fill_r <= fill_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
          end
          pass_r  <= '0;
          shamt_r <= '0;
          idx_r   <= '0;
          bidx_r  <= '0;
        end
        rsort_pkg::ST_CLEAR: begin
          bidx_r <= bidx_last ? '0 : bidx_r + 1'b1;
          idx_r  <= '0;
        end
        rsort_pkg::ST_HIST_WR: begin
          idx_r <= key_last ? '0 : idx_inc;
        end
        rsort_pkg::ST_PREFIX: begin
          bidx_r <= bidx_done ? '0 : bidx_r + 1'b1;
        end
        rsort_pkg::ST_SCAT_WR: begin
          idx_r <= key_last ? '0 : idx_inc;
          if (key_last && !pass_last) begin
            pass_r  <= pass_r + 1'b1;
            shamt_r <= shamt_r + SH_W'(DIGIT_BITS);
          end
        end
        rsort_pkg::ST_OUT_LD: begin
          out_valid_r <= 1'b1;
        end
        rsort_pkg::ST_OUT_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (key_last) begin
              fill_r <= '0;
              ovf_r  <= 1'b0;
              idx_r  <= '0;
            end else begin
              idx_r <= idx_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rsort_pkg::ST_HIST_RD || state_r == rsort_pkg::ST_SCAT_RD) begin
      dig_r  <= digit;
      hold_r <= src_q;
    end
    if (state_r == rsort_pkg::ST_OUT_LD) begin
      out_data_r.key_out      <= rsort_pkg::OUT_KEY_W'(dst_q);
      out_data_r.end_of_batch <= key_last;
      out_data_r.dropped      <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond store depth");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid_r))
    else $error("input open while a sorted key is pending");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rsort_pkg::ST_SCAT_WR |-> bkt_rdata < fill_r)
    else $error("scatter position outside the batch");

  a_batch_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && out_data_r.end_of_batch) |=>
      (fill_r == '0 && !ovf_r && in_ready))
    else $error("batch state not cleared after final key");

endmodule

### rtl/core/radix_sort_u32_top.sv
// ----------------------------------------------------------------------------
// radix_sort_u32_top: batch sorter for unsigned keys, LSD radix base 2^D
// Collects a batch, sorts it with stable counting passes and streams it out.
// ----------------------------------------------------------------------------
// Loading accepts one key per cycle; in_ready is high only while loading.
// After the closing key, P = ceil(KEY_WIDTH/DIGIT_BITS) passes each run a table
// clear, histogram, prefix and scatter in turn on the single bucket memory and
// its shared adder. Then each sorted key is read, loaded into the output
// register and held until out_ready takes it.
// rst_n (synchronous) empties the batch; stores need no clearing pass.
module radix_sort_u32_top #(
  parameter int CAPACITY   = rsort_pkg::CAPACITY_DEF,
  parameter int DIGIT_BITS = rsort_pkg::DIGIT_BITS_DEF,
  parameter int KEY_WIDTH  = rsort_pkg::KEY_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rsort_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsort_pkg::out_item_t out_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // key store ports; both stores share read address and write data
  logic                  key_we_a;
  logic                  key_we_b;
  logic [IDX_W-1:0]      key_waddr;
  logic [KEY_WIDTH-1:0]  key_wdata;
  logic [IDX_W-1:0]      key_raddr;
  logic [KEY_WIDTH-1:0]  key_rdata_a;
  logic [KEY_WIDTH-1:0]  key_rdata_b;

  // bucket unit: counts, offsets and scatter positions
  rsort_pkg::bkt_ctl_t   bkt_ctl;
  logic [DIGIT_BITS-1:0] bkt_raddr;
  logic [DIGIT_BITS-1:0] bkt_waddr;
  logic [CNT_W-1:0]      bkt_rdata;

  // sequencer: owns the handshakes, counters and the output register
  rsort_seq #(
    .CAPACITY   (CAPACITY),
    .DIGIT_BITS (DIGIT_BITS),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .key_we_a    (key_we_a),
    .key_we_b    (key_we_b),
    .key_waddr   (key_waddr),
    .key_wdata   (key_wdata),
    .key_raddr   (key_raddr),
    .key_rdata_a (key_rdata_a),
    .key_rdata_b (key_rdata_b),
    .bkt_ctl     (bkt_ctl),
    .bkt_raddr   (bkt_raddr),
    .bkt_waddr   (bkt_waddr),
    .bkt_rdata   (bkt_rdata)
  );

  // store a: loaded from the input, target of odd passes
  rsort_key_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH)
  ) u_store_a (
    .clk   (clk),
    .we    (key_we_a),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata_a)
  );

  // store b: target of even passes
  rsort_key_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH)
  ) u_store_b (
    .clk   (clk),
    .we    (key_we_b),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata_b)
  );

  rsort_bkt_unit #(
    .CAPACITY   (CAPACITY),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_bkt (
    .clk     (clk),
    .ctl     (bkt_ctl),
    .rd_addr (bkt_raddr),
    .wr_addr (bkt_waddr),
    .rdata   (bkt_rdata)
  );

endmodule
